>>> hw/rtl/kla_pkg.sv
// Shared types and constants for the key lockout / auto-repeat block.
// No dependencies; imported by every module of the block.

package kla_pkg;

   localparam int CFG_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int NOW_BITS = 32;
   localparam int REQ_TDATA_BITS = 40;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 8;

   // Register indexes on the csr channel
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOCKOUT_MS = 2'd0,
      CSR_HOLD_DELAY_MS = 2'd1,
      CSR_REPEAT_INTERVAL_MS = 2'd2
   } csr_index_type;

   localparam logic [CFG_BITS-1:0] LOCKOUT_MS_RESET = 16'd200;
   localparam logic [CFG_BITS-1:0] HOLD_DELAY_MS_RESET = 16'd2000;
   localparam logic [CFG_BITS-1:0] REPEAT_INTERVAL_MS_RESET = 16'd150;

   typedef struct packed {
      logic [CFG_BITS-1:0] lockout_ms;
      logic [CFG_BITS-1:0] hold_delay_ms;
      logic [CFG_BITS-1:0] repeat_interval_ms;
   } cfg_type;

   // Per-button command for the item in the input register
   typedef struct packed {
      logic update;   // item leaves the input register this cycle
      logic clear;
      logic hit;      // sample belongs to this button
      logic level;
   } btn_cmd_type;

   typedef struct packed {
      logic held;
      logic lockout;
      logic repeating;
   } btn_status_type;

endpackage

>>> hw/rtl/key_lockout_autorepeat.sv
// Top level of the key lockout / auto-repeat qualifier.
// Depends on kla_pkg, kla_cfg and kla_button.
//
// Usage:
//   req_* carries one item per transfer: a clear (req_tuser[0]) or a sample
//   of the button named by req_tuser[1], with its pressed level and a
//   millisecond timestamp in req_tdata.
//   rsp_* returns exactly one result per item: press_event in rsp_tdata[0].
//   csr_* writes lockout_ms (0), hold_delay_ms (1) and repeat_interval_ms (2);
//   writes are always taken, other indexes are dropped.
// Pipeline: an accepted item moves from the input register to the result
//   register, which drives rsp_tvalid and rsp_tdata.
// Throughput: one item per clock while the result is taken (see Stall). The
//   per-button state is updated as the item moves from the input register to
//   the result register, so the next item already sees it with no bubble.
// Reset: synchronous, active high; both pipeline registers empty, all
//   button flags and timestamps zero, registers at 200 / 2000 / 150.
// Stall: while rsp_tready is low the result holds; the input register
//   still fills, and req_tready drops once both registers are occupied.

module key_lockout_autorepeat import kla_pkg::*; #(
   parameter int NUM_BUTTONS = 2,
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // tdata: [0] level_pressed, [32:1] now_ms, [39:33] zero
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // tuser: [0] clear_all, [1] button_select
   input  logic [REQ_TUSER_BITS-1:0] req_tuser,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // tdata: [0] press_event, [7:1] zero
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   cfg_type cfg;

   logic                 in_valid_ff, in_valid_in;
   logic                 in_clear_ff, in_sel_ff, in_level_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_event_ff, out_event_in;
   logic                 advance, req_fire;

   logic [NUM_BUTTONS-1:0] event_vec;
   logic [NUM_BUTTONS-1:0] held_vec;
   btn_status_type         status_arr [NUM_BUTTONS];

   kla_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire = req_tvalid && req_tready;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
      btn_cmd_type cmd;

      assign cmd.update = in_valid_ff && advance;
      assign cmd.clear = in_clear_ff;
      assign cmd.hit = int'(in_sel_ff) == i;
      assign cmd.level = in_level_ff;

      kla_button #(
         .TIME_BITS (TIME_BITS)
      ) u_button (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .now       (in_now_ff),
         .cfg       (cfg),
         .event_out (event_vec[i]),
         .status    (status_arr[i])
      );

      assign held_vec[i] = status_arr[i].held;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      out_event_in = out_event_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_event_in = |event_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_clear_ff <= req_tuser[0];
         in_sel_ff <= req_tuser[1];
         in_level_ff <= req_tdata[0];
         in_now_ff <= TIME_BITS'(req_tdata[NOW_BITS:1]);
      end
      out_event_ff <= out_event_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = RSP_TDATA_BITS'(out_event_ff);

   // A clear never yields an event
   a_clear_no_event: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && in_clear_ff |=> !out_event_ff)
      else $error("clear item produced a press event");

   // After a clear no button is held
   a_clear_releases: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && in_clear_ff |=> held_vec == '0)
      else $error("button still held after clear");

   // Only the selected button can fire
   a_single_event: assert property (@(posedge clock) disable iff (reset)
      $onehot0(event_vec))
      else $error("more than one button raised an event");

   // A fresh event leaves the button held
   a_event_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && (|event_vec) |=> (|held_vec))
      else $error("event without a held button");

endmodule

>>> hw/rtl/kla_cfg.sv
// Configuration registers for lockout, hold delay and repeat interval.
// Depends on kla_pkg.

module kla_cfg import kla_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LOCKOUT_MS:         cfg_in.lockout_ms = csr_data;
            CSR_HOLD_DELAY_MS:      cfg_in.hold_delay_ms = csr_data;
            CSR_REPEAT_INTERVAL_MS: cfg_in.repeat_interval_ms = csr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lockout_ms <= LOCKOUT_MS_RESET;
         cfg_ff.hold_delay_ms <= HOLD_DELAY_MS_RESET;
         cfg_ff.repeat_interval_ms <= REPEAT_INTERVAL_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/kla_button.sv
// One button's press qualifier: flags, timestamps and the lockout,
// hold and repeat compares. Depends on kla_pkg.

module kla_button import kla_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  btn_cmd_type          cmd,
   input  logic [TIME_BITS-1:0] now,
   input  cfg_type              cfg,
   output logic                 event_out,
   output btn_status_type       status
);

   logic                 held_ff, held_in;
   logic                 lockout_ff, lockout_in;
   logic                 repeating_ff, repeating_in;
   logic [TIME_BITS-1:0] lockout_start_ff, lockout_start_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic [TIME_BITS-1:0] last_repeat_ff, last_repeat_in;

   logic [TIME_BITS-1:0] lock_age, hold_age, repeat_age;
   logic                 lock_done, hold_done, repeat_done, lock_live;

   // Differences wrap at the timestamp width
   assign lock_age = now - lockout_start_ff;
   assign hold_age = now - press_start_ff;
   assign repeat_age = now - last_repeat_ff;

   assign lock_done = lock_age >= TIME_BITS'(cfg.lockout_ms);
   assign hold_done = hold_age >= TIME_BITS'(cfg.hold_delay_ms);
   assign repeat_done = repeat_age >= TIME_BITS'(cfg.repeat_interval_ms);
   assign lock_live = lockout_ff && !lock_done;

   always_comb begin
      held_in = held_ff;
      lockout_in = lockout_ff;
      repeating_in = repeating_ff;
      lockout_start_in = lockout_start_ff;
      press_start_in = press_start_ff;
      last_repeat_in = last_repeat_ff;
      event_out = 1'b0;
      if (cmd.clear) begin
         held_in = 1'b0;
         lockout_in = 1'b0;
         repeating_in = 1'b0;
      end else if (cmd.hit) begin
         lockout_in = lock_live;
         if (!cmd.level) begin
            held_in = 1'b0;
         end else if (lock_live) begin
            event_out = 1'b0;
         end else if (!held_ff) begin
            // fresh press: event and new lockout window
            held_in = 1'b1;
            press_start_in = now;
            last_repeat_in = now;
            repeating_in = 1'b0;
            lockout_in = 1'b1;
            lockout_start_in = now;
            event_out = 1'b1;
         end else if (hold_done) begin
            if (!repeating_ff) begin
               repeating_in = 1'b1;
               last_repeat_in = now;
               event_out = 1'b1;
            end else if (repeat_done) begin
               last_repeat_in = now;
               event_out = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         lockout_ff <= 1'b0;
         repeating_ff <= 1'b0;
         lockout_start_ff <= '0;
         press_start_ff <= '0;
         last_repeat_ff <= '0;
      end else if (cmd.update) begin
         held_ff <= held_in;
         lockout_ff <= lockout_in;
         repeating_ff <= repeating_in;
         lockout_start_ff <= lockout_start_in;
         press_start_ff <= press_start_in;
         last_repeat_ff <= last_repeat_in;
      end
   end

   assign status.held = held_ff;
   assign status.lockout = lockout_ff;
   assign status.repeating = repeating_ff;

endmodule
